### hw/rtl/pwm_input_duty_decoder_assert.svh
// Assertion macros for the PWM input duty decoder.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef PWM_INPUT_DUTY_DECODER_ASSERT_SVH
`define PWM_INPUT_DUTY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Implication or sequence checked at every clock edge outside reset.
`define PWMDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Plain state invariant, checked at every clock edge outside reset.
`define PWMDD_ASSERT_INV(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define PWMDD_ASSERT(label, prop, msg)
`define PWMDD_ASSERT_INV(label, expr, msg)
`endif
`endif

### hw/rtl/pwmdd_pkg.sv
// Shared types and constants of the PWM input duty decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package pwmdd_pkg;

  localparam int DIV_W    = 27;  // dividend / quotient width of the shared divider
  localparam int STEP_W   = 5;   // divider step counter
  localparam int FREQ_W   = 27;
  localparam int DUTY_W   = 7;
  localparam int REF_W    = 16;
  localparam int LIMIT_W  = 16;
  localparam int EVCNT_W  = 17;  // timeout and equal-reading counters
  localparam int HZ_W     = 27;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 56;  // 51 field bits padded to whole bytes
  localparam int OUT_FIELD_W = FREQ_W + DUTY_W + REF_W + 1;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
  localparam logic [7:0]        REF_DIVISOR = 8'd99;
  localparam logic [STEP_W-1:0] DUTY_STEPS = 5'd7;
  localparam logic [STEP_W-1:0] WIDE_STEPS = 5'd27;

  // s_tuser bit positions
  localparam int EV_OVF = 0;
  localparam int EV_CAP = 1;

  localparam logic [LIMIT_W-1:0] STABLE_LIMIT_RST = 16'd10;
  localparam logic [HZ_W-1:0]    CLOCK_HZ_RST     = 27'd1000000;
  localparam logic [REF_W-1:0]   MIN_REF_RST      = 16'd0;
  localparam logic [REF_W-1:0]   MAX_REF_RST      = 16'd65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STABLE_LIMIT     = 2'd0,
    REG_CAPTURE_CLOCK_HZ = 2'd1,
    REG_MIN_REF_FREQ     = 2'd2,
    REG_MAX_REF_FREQ     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] stable_limit;
    logic [HZ_W-1:0]    capture_clock_hz;
    logic [REF_W-1:0]   min_ref_freq;
    logic [REF_W-1:0]   max_ref_freq;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/pwmdd_cfg_regs.sv
// Configuration register file of the PWM input duty decoder.
// Depends on pwmdd_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module pwmdd_cfg_regs
  import pwmdd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [HZ_W-1:0]      cfg_data,
  output cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_limit     <= STABLE_LIMIT_RST;
      cfg.capture_clock_hz <= CLOCK_HZ_RST;
      cfg.min_ref_freq     <= MIN_REF_RST;
      cfg.max_ref_freq     <= MAX_REF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STABLE_LIMIT:     cfg.stable_limit     <= cfg_data[LIMIT_W-1:0];
        REG_CAPTURE_CLOCK_HZ: cfg.capture_clock_hz <= cfg_data;
        REG_MIN_REF_FREQ:     cfg.min_ref_freq     <= cfg_data[REF_W-1:0];
        REG_MAX_REF_FREQ:     cfg.max_ref_freq     <= cfg_data[REF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pwmdd_div_unit.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pwmdd_pkg and pwm_input_duty_decoder_assert.svh.
`default_nettype none
`include "pwm_input_duty_decoder_assert.svh"

module pwmdd_div_unit
  import pwmdd_pkg::*;
#(
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_cmd_t         cmd,
  input  wire logic [DEN_W-1:0] rem_init,   // must be below divisor
  input  wire logic [DIV_W-1:0] num_init,   // dividend bits, msb first
  input  wire logic [DEN_W-1:0] divisor,
  output div_stat_t             stat,
  output logic      [DIV_W-1:0] quotient
);

  logic [DEN_W-1:0]  rem;
  logic [DIV_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] count;
  logic [STEP_W-1:0] last;
  logic              busy;

  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  trial;
  logic              fits;

  assign shifted = {rem, num[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};
  assign fits    = ~trial[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= rem_init;
      num  <= num_init;
      den  <= divisor;
      last <= cmd.steps - 1'b1;
    end else if (busy) begin
      rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      num <= {num[DIV_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (count == last);
  assign quotient  = num;

  `PWMDD_ASSERT(a_start_busy, cmd.start |=> stat.busy, "divider did not start")
  `PWMDD_ASSERT(a_done_idle, stat.done && !cmd.start |=> !stat.busy, "divider ran past last step")
  `PWMDD_ASSERT(a_rem_bound, busy |-> (rem < den), "partial remainder not below divisor")

endmodule

`default_nettype wire

### hw/rtl/pwm_input_duty_decoder.sv
// Per accepted item: with a valid capture, a 7-step duty divide (skipped when the high time
// clamps the duty) and a 27-step frequency divide; then the reference map (REF_MUL, REF_DIV,
// REF_FIX, the last two skipped when the accepted duty is zero), then ST_DONE, which waits while
// a stalled m_tready holds the previous beat. A new item is taken only back in ST_IDLE.
// Reset (rst, synchronous): registers to defaults, counters and duty state to zero, no beat.
// Depends on pwmdd_pkg, pwmdd_cfg_regs, pwmdd_div_unit, pwm_input_duty_decoder_assert.svh.
`default_nettype none
`include "pwm_input_duty_decoder_assert.svh"

module pwm_input_duty_decoder
  import pwmdd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  localparam int IN_W      = 1 + 2 * COUNT_WIDTH,
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input beats
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // pin_level, period_count, high_count, zero pad
  input  wire logic [1:0]            s_tuser,   // overflow_event, capture_event
  // result beats
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // frequency, duty_percent, ref_freq, drive_on, pad
  output logic [0:0]                 m_tuser,   // bad_capture
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [HZ_W-1:0]       cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUTY_DIV,
    ST_DUTY_UPD,
    ST_FREQ_DIV,
    ST_FREQ_UPD,
    ST_REF_MUL,
    ST_REF_DIV,
    ST_REF_FIX,
    ST_DONE
  } state_t;

  localparam int HP_W = COUNT_WIDTH + DUTY_W;  // high_count * 100

  // x / 99 as (x * ceil(2^29 / 99)) >> 29, exact for x below 2^23
  localparam logic [22:0] REF_RECIP       = 23'd5422939;
  localparam int          REF_RECIP_SHIFT = 29;

  cfg_t cfg;

  pwmdd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------- shared divider
  div_cmd_t                 div_cmd;
  div_stat_t                div_stat;
  logic [COUNT_WIDTH-1:0]   div_rem_init;
  logic [DIV_W-1:0]         div_num_init;
  logic [COUNT_WIDTH-1:0]   div_den;
  logic [DIV_W-1:0]         div_quot;

  pwmdd_div_unit #(
    .DEN_W (COUNT_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .cmd       (div_cmd),
    .rem_init  (div_rem_init),
    .num_init  (div_num_init),
    .divisor   (div_den),
    .stat      (div_stat),
    .quotient  (div_quot)
  );

  // ---------------------------------------------------------------- state
  state_t                  state;
  logic [EVCNT_W-1:0]      timeout_count;
  logic [EVCNT_W-1:0]      equal_count;
  logic [DUTY_W-1:0]       previous_duty;
  logic [DUTY_W-1:0]       accepted_duty;
  logic [FREQ_W-1:0]       measured_frequency;

  // item registers (payload, no reset)
  logic [COUNT_WIDTH-1:0]  period_q;
  logic                    duty_full_q;  // high >= period, duty clamps to 100
  logic                    bad_q;
  logic signed [24:0]      ref_prod;
  logic [REF_W-1:0]        ref_quot;
  logic [REF_W-1:0]        ref_q;

  // ---------------------------------------------------------------- input decode
  logic                    in_accept;
  logic                    in_ovf;
  logic                    in_cap;
  logic                    in_pin;
  logic [COUNT_WIDTH-1:0]  in_period;
  logic [COUNT_WIDTH-1:0]  in_high;
  logic [HP_W-1:0]         high_ext;
  logic [HP_W-1:0]         high100;
  logic                    period_zero;
  logic                    high_full;

  assign in_accept   = s_tvalid && s_tready;
  assign in_ovf      = s_tuser[EV_OVF];
  assign in_cap      = s_tuser[EV_CAP];
  assign in_pin      = s_tdata[0];
  assign in_period   = s_tdata[COUNT_WIDTH:1];
  assign in_high     = s_tdata[2*COUNT_WIDTH:COUNT_WIDTH+1];
  assign high_ext    = {{DUTY_W{1'b0}}, in_high};
  // x*100 = x*64 + x*32 + x*4
  assign high100     = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);
  assign period_zero = (in_period == '0);
  assign high_full   = (in_high >= in_period);

  // overflow handling happens at the accept edge, ahead of the capture
  logic [EVCNT_W-1:0] timeout_inc;
  logic               timeout_hit;
  assign timeout_inc = timeout_count + 1'b1;
  assign timeout_hit = timeout_inc > {1'b0, cfg.stable_limit};

  // duty reading once the divide is through
  logic [DUTY_W-1:0]  duty_val;
  logic [EVCNT_W-1:0] equal_inc;
  logic               equal_hit;
  assign duty_val  = duty_full_q ? DUTY_FULL : div_quot[DUTY_W-1:0];
  assign equal_inc = equal_count + 1'b1;
  assign equal_hit = equal_inc > {1'b0, cfg.stable_limit};

  // reference map: min + floor((max-min)*(duty-1)/99)
  logic signed [16:0]  ref_diff;
  logic signed [7:0]   ref_dm1;
  logic signed [24:0]  ref_prod_next;
  logic [22:0]         ref_mag;
  logic                ref_neg;
  logic [45:0]         ref_recip_prod;
  logic [22:0]         ref_back;
  logic                ref_rem_nz;
  logic [REF_W:0]      ref_qmag;
  logic [REF_W-1:0]    ref_next;

  assign ref_diff      = $signed({1'b0, cfg.max_ref_freq}) - $signed({1'b0, cfg.min_ref_freq});
  assign ref_dm1       = $signed({1'b0, accepted_duty - 1'b1});
  assign ref_prod_next = ref_diff * ref_dm1;
  assign ref_neg       = ref_prod[24];
  // |product| is at most 65535 * 99, below 2^23
  assign ref_mag       = ref_neg ? 23'(-ref_prod) : 23'(ref_prod);
  assign ref_recip_prod = {23'd0, ref_mag} * {23'd0, REF_RECIP};
  assign ref_back      = {7'd0, ref_quot} * {15'd0, REF_DIVISOR};
  assign ref_rem_nz    = (ref_back != ref_mag);
  // a negative product floors away from zero
  assign ref_qmag      = {1'b0, ref_quot}
                         + {{REF_W{1'b0}}, (ref_neg && ref_rem_nz)};
  assign ref_next      = ref_neg ? cfg.min_ref_freq - ref_qmag[REF_W-1:0]
                                 : cfg.min_ref_freq + ref_qmag[REF_W-1:0];

  // ---------------------------------------------------------------- divider commands
  always_comb begin
    div_cmd      = '0;
    div_rem_init = '0;
    div_num_init = '0;
    div_den      = '0;
    case (state)
      ST_IDLE: begin
        // high*100 / period with the top bits preloaded: quotient fits in 7 bits
        div_cmd.start = in_accept && in_cap && !period_zero && !high_full;
        div_cmd.steps = DUTY_STEPS;
        div_rem_init  = high100[HP_W-1:DUTY_W];
        div_num_init  = {high100[DUTY_W-1:0], {(DIV_W-DUTY_W){1'b0}}};
        div_den       = in_period;
      end
      ST_DUTY_UPD: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = WIDE_STEPS;
        div_num_init  = cfg.capture_clock_hz;
        div_den       = period_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      timeout_count      <= '0;
      equal_count        <= '0;
      previous_duty      <= '0;
      accepted_duty      <= '0;
      measured_frequency <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      // ST_DONE owns m_tvalid while it runs
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_ovf) begin
              if (timeout_hit) begin
                timeout_count <= '0;
                accepted_duty <= in_pin ? '0 : DUTY_FULL;
              end else begin
                timeout_count <= timeout_inc;
              end
            end
            if (in_cap && !period_zero) begin
              state <= high_full ? ST_DUTY_UPD : ST_DUTY_DIV;
            end else begin
              state <= ST_REF_MUL;
            end
          end
        end
        ST_DUTY_DIV: begin
          if (div_stat.done) begin
            state <= ST_DUTY_UPD;
          end
        end
        ST_DUTY_UPD: begin
          timeout_count <= '0;
          previous_duty <= duty_val;
          if (duty_val == previous_duty) begin
            if (equal_hit) begin
              equal_count   <= '0;
              accepted_duty <= duty_val;
            end else begin
              equal_count <= equal_inc;
            end
          end else begin
            equal_count <= '0;
          end
          state <= ST_FREQ_DIV;
        end
        ST_FREQ_DIV: begin
          if (div_stat.done) begin
            state <= ST_FREQ_UPD;
          end
        end
        ST_FREQ_UPD: begin
          measured_frequency <= div_quot[FREQ_W-1:0];
          state              <= ST_REF_MUL;
        end
        ST_REF_MUL: begin
          state <= (accepted_duty == '0) ? ST_DONE : ST_REF_DIV;
        end
        ST_REF_DIV: begin
          state <= ST_REF_FIX;
        end
        ST_REF_FIX: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // the previous beat may still sit in the output register
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      period_q    <= in_period;
      duty_full_q <= high_full;
      bad_q       <= in_cap && period_zero;
    end
    if (state == ST_REF_MUL) begin
      ref_prod <= ref_prod_next;
      ref_q    <= cfg.min_ref_freq;
    end
    if (state == ST_REF_DIV) begin
      ref_quot <= ref_recip_prod[REF_RECIP_SHIFT +: REF_W];
    end
    if (state == ST_REF_FIX) begin
      ref_q <= ref_next;
    end
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {{(OUT_DATA_W-OUT_FIELD_W){1'b0}},
                  (accepted_duty != '0), ref_q, accepted_duty, measured_frequency};
      m_tuser <= bad_q;
    end
  end

  assign s_tready = (state == ST_IDLE);

  `PWMDD_ASSERT(a_one_item, in_accept |=> !s_tready, "second item taken while busy")
  `PWMDD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat dropped")
  `PWMDD_ASSERT_INV(a_duty_range, accepted_duty <= DUTY_FULL, "accepted duty above 100")
  `PWMDD_ASSERT_INV(a_prev_range, previous_duty <= DUTY_FULL, "duty reading above 100")

endmodule

`default_nettype wire

### tb/pwm_input_duty_decoder_tb.sv
// Self-checking testbench for pwm_input_duty_decoder: directed rows, then random event runs.
// Each beat's report is predicted in-bench and compared with the result stream in order.
// Depends on pwmdd_pkg and the pwm_input_duty_decoder RTL.
`default_nettype none

module pwm_input_duty_decoder_tb;
  import pwmdd_pkg::*;

  localparam int          CNT_W       = 16;
  localparam int          IN_DATA_W   = ((1 + 2 * CNT_W + 7) / 8) * 8;
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES = 100;   // extra cycles run after the last report is back
  localparam int          NUM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS = 90;

  // one report, field for field as on m_tdata / m_tuser
  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [DUTY_W-1:0] duty;
    logic [REF_W-1:0]  ref_freq;
    logic              drive_on;
    logic              bad_capture;
  } duty_report_t;

  // directed stimulus row: either a register write or one input beat
  typedef struct {
    logic              is_cfg;
    cfg_reg_t          reg_idx;
    logic [HZ_W-1:0]   reg_value;
    logic              ovf;
    logic              cap;
    logic              pin;
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  high;
    logic              typed;   // report typed in below instead of predicted
    duty_report_t      report;
  } dir_row_t;

  localparam duty_report_t NO_REPORT = '0;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index;
  logic [HZ_W-1:0]      cfg_data;

  pwm_input_duty_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [LIMIT_W-1:0] c_limit;
  logic [HZ_W-1:0]    c_clock_hz;
  logic [REF_W-1:0]   c_min_ref;
  logic [REF_W-1:0]   c_max_ref;

  // predictor copy of the decoder state
  logic [EVCNT_W-1:0] p_timeout;
  logic [EVCNT_W-1:0] p_equal;
  logic [DUTY_W-1:0]  p_prev_duty;
  logic [DUTY_W-1:0]  p_duty;
  logic [FREQ_W-1:0]  p_freq;

  duty_report_t expected_reports[$];
  dir_row_t     directed_rows[$];
  logic         failed = 1'b0;
  logic         steady = 1'b0;  // when set, neither side idles
  int unsigned  idle_cycles = 0;
  int unsigned  stall_left = 0;

  // register settings for the random phases; extremes included
  int unsigned phase_limit [NUM_PHASES] = '{3, 10, 65535, 1, 2, 0};
  int unsigned phase_clock [NUM_PHASES] = '{100000000, 1, 72000000, 0, 12345678, 1000000};
  int unsigned phase_min   [NUM_PHASES] = '{100, 0, 65535, 0, 65535, 1234};
  int unsigned phase_max   [NUM_PHASES] = '{2000, 65535, 0, 0, 65535, 4321};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // linear map of duty 1..100 onto min..max, flooring toward minus infinity
  function automatic logic [REF_W-1:0] ref_for_duty(logic [DUTY_W-1:0] duty);
    longint mx, mn, dm, span, num, q, divisor;
    if (duty == '0) return c_min_ref;
    mx = c_max_ref;
    mn = c_min_ref;
    dm = duty;
    divisor = REF_DIVISOR;
    span = mx - mn;
    num = span * (dm - 1);
    if (num >= 0) q = num / divisor;
    else q = -((-num + divisor - 1) / divisor);
    return REF_W'(mn + q);
  endfunction

  // advance the state by one input beat and return its report
  task automatic predict_report(input logic ovf, input logic cap, input logic pin,
                                input logic [CNT_W-1:0] period,
                                input logic [CNT_W-1:0] high,
                                output duty_report_t rep);
    longint unsigned reading;
    logic bad;
    bad = 1'b0;
    if (ovf) begin
      p_timeout = p_timeout + 1'b1;
      if (p_timeout > c_limit) begin
        p_timeout = '0;
        p_duty = pin ? '0 : DUTY_FULL;
      end
    end
    if (cap) begin
      if (period == '0) begin
        // zero period: capture dropped, timeout keeps running
        bad = 1'b1;
      end else begin
        reading = high;
        reading = reading * 100 / period;
        if (reading > DUTY_FULL) reading = DUTY_FULL;
        p_timeout = '0;
        p_freq = FREQ_W'(c_clock_hz / period);
        if (DUTY_W'(reading) == p_prev_duty) begin
          p_equal = p_equal + 1'b1;
          if (p_equal > c_limit) begin
            p_equal = '0;
            p_duty = DUTY_W'(reading);
          end
        end else begin
          p_equal = '0;
        end
        p_prev_duty = DUTY_W'(reading);
      end
    end
    rep.frequency   = p_freq;
    rep.duty        = p_duty;
    rep.ref_freq    = ref_for_duty(p_duty);
    rep.drive_on    = (p_duty != '0);
    rep.bad_capture = bad;
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [CNT_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return CNT_W'($urandom_range(1, 300));
    if (r < 8) return CNT_W'($urandom_range(1, 65535));
    return CNT_W'($urandom_range(65000, 65535));
  endfunction

  // high time mostly within the period, sometimes past it (clamped duty)
  function automatic logic [CNT_W-1:0] pick_high(logic [CNT_W-1:0] period);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return CNT_W'($urandom_range(0, period));
    if (r < 17) return CNT_W'($urandom_range(0, 65535));
    if (r < 18) return period;
    return CNT_W'(period + 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (inputs change on the falling edge, handshakes seen on the rising one)
  // ---------------------------------------------------------------------------

  task automatic send_beat(input logic ovf, input logic cap, input logic pin,
                           input logic [CNT_W-1:0] period,
                           input logic [CNT_W-1:0] high,
                           input logic typed, input duty_report_t typed_rep);
    int unsigned gap;
    duty_report_t rep;
    gap = idle_gap();
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = '0;
    s_tdata[0] = pin;
    s_tdata[1 +: CNT_W] = period;
    s_tdata[1 + CNT_W +: CNT_W] = high;
    s_tuser[EV_OVF] = ovf;
    s_tuser[EV_CAP] = cap;
    do @(posedge clk); while (!s_tready);
    predict_report(ovf, cap, pin, period, high, rep);
    expected_reports.push_back(typed ? typed_rep : rep);
  endtask

  // registers change only once every report is back
  task automatic write_register(input cfg_reg_t idx, input logic [HZ_W-1:0] value);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STABLE_LIMIT:     c_limit    = LIMIT_W'(value);
      REG_CAPTURE_CLOCK_HZ: c_clock_hz = value;
      REG_MIN_REF_FREQ:     c_min_ref  = REF_W'(value);
      REG_MAX_REF_FREQ:     c_max_ref  = REF_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(input logic ovf, input logic cap, input logic pin,
                         input logic [CNT_W-1:0] period, input logic [CNT_W-1:0] high,
                         input logic typed, input duty_report_t rep);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = REG_STABLE_LIMIT;
    row.reg_value = '0;
    row.ovf = ovf;
    row.cap = cap;
    row.pin = pin;
    row.period = period;
    row.high = high;
    row.typed = typed;
    row.report = rep;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg_row(input cfg_reg_t idx, input logic [HZ_W-1:0] value);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_value = value;
    row.ovf = 1'b0;
    row.cap = 1'b0;
    row.pin = 1'b0;
    row.period = '0;
    row.high = '0;
    row.typed = 1'b0;
    row.report = NO_REPORT;
    directed_rows.push_back(row);
  endtask

  // Random traffic: mostly runs of equal captures (to reach duty acceptance)
  // and runs of overflows (to reach the timeout), the rest single noisy beats.
  task automatic run_random(input int unsigned target);
    int unsigned sent, run_len, kind, k;
    logic [CNT_W-1:0] period, high;
    logic pin;
    sent = 0;
    while (sent < target) begin
      steady = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        period = pick_period();
        high = pick_high(period);
        run_len = (c_limit < 16) ? $urandom_range(1, c_limit + 4) : $urandom_range(1, 12);
        for (k = 0; k < run_len; k++) begin
          send_beat($urandom_range(0, 15) == 0, 1'b1, 1'($urandom_range(0, 1)),
                    period, high, 1'b0, NO_REPORT);
        end
      end else if (kind < 80) begin
        pin = 1'($urandom_range(0, 1));
        run_len = (c_limit < 16) ? $urandom_range(1, c_limit + 3) : $urandom_range(1, 12);
        for (k = 0; k < run_len; k++) begin
          send_beat(1'b1, 1'b0, pin, CNT_W'($urandom_range(0, 65535)),
                    CNT_W'($urandom_range(0, 65535)), 1'b0, NO_REPORT);
        end
      end else begin
        run_len = 1;
        period = ($urandom_range(0, 3) == 0) ? '0 : pick_period();
        send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)),
                  period, CNT_W'($urandom_range(0, 65535)), 1'b0, NO_REPORT);
      end
      sent += run_len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      stall_left = idle_gap();
      m_tready = (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    duty_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result beat with no expectation, expected none, actual %h",
                 $time, m_tdata);
        failed = 1'b1;
      end else begin
        want = expected_reports.pop_front();
        compare_field("frequency", want.frequency, m_tdata[FREQ_W-1:0]);
        compare_field("duty_percent", want.duty, m_tdata[FREQ_W +: DUTY_W]);
        compare_field("ref_freq", want.ref_freq, m_tdata[FREQ_W + DUTY_W +: REF_W]);
        compare_field("drive_on", want.drive_on, m_tdata[FREQ_W + DUTY_W + REF_W]);
        compare_field("bad_capture", want.bad_capture, m_tuser[0]);
      end
    end
  end

  // watchdog: nothing handshaking for too long means a hang
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_STABLE_LIMIT;
    cfg_data  = '0;

    c_limit    = STABLE_LIMIT_RST;
    c_clock_hz = CLOCK_HZ_RST;
    c_min_ref  = MIN_REF_RST;
    c_max_ref  = MAX_REF_RST;
    p_timeout   = '0;
    p_equal     = '0;
    p_prev_duty = '0;
    p_duty      = '0;
    p_freq      = '0;

    // reset defaults: nothing measured yet
    add_row(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b1, {27'd0, 7'd0, 16'd0, 1'b0, 1'b0});
    // zero period is flagged and dropped
    add_row(1'b0, 1'b1, 1'b0, 16'd0, 16'd5, 1'b1, {27'd0, 7'd0, 16'd0, 1'b0, 1'b1});
    // first good capture: frequency updates, duty not yet accepted
    add_row(1'b0, 1'b1, 1'b0, 16'd1000, 16'd250, 1'b1, {27'd1000, 7'd0, 16'd0, 1'b0, 1'b0});
    add_cfg_row(REG_STABLE_LIMIT, 27'd0);
    // timeout with pin low -> full duty, with pin high -> zero duty
    add_row(1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 1'b1, {27'd1000, 7'd100, 16'd65535, 1'b1, 1'b0});
    add_row(1'b1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, {27'd1000, 7'd0, 16'd0, 1'b0, 1'b0});
    add_row(1'b0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPORT);
    // high time past the period clamps to 100, matches the last reading
    add_row(1'b0, 1'b1, 1'b1, 16'd1, 16'hFFFF, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b0, 16'd100, 16'd1, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b0, 16'd100, 16'd1, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b1, 16'd200, 16'd199, 1'b0, NO_REPORT);
    // both events: overflow first, then the capture
    add_row(1'b1, 1'b1, 1'b1, 16'd200, 16'd199, 1'b0, NO_REPORT);
    // overflow plus zero-period capture: timeout still runs
    add_row(1'b1, 1'b1, 1'b0, 16'd0, 16'h8000, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b0, 16'd3, 16'd0, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b1, 16'd3, 16'd0, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b0, 16'hFFFF, 16'h8000, 1'b0, NO_REPORT);
    // max below min, clock at zero
    add_cfg_row(REG_MIN_REF_FREQ, 27'd60000);
    add_cfg_row(REG_MAX_REF_FREQ, 27'd5);
    add_cfg_row(REG_CAPTURE_CLOCK_HZ, 27'd0);
    add_row(1'b0, 1'b1, 1'b0, 16'hFFFF, 16'h8000, 1'b0, NO_REPORT);
    add_row(1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b1, 16'd7, 16'd7, 1'b0, NO_REPORT);
    add_row(1'b0, 1'b1, 1'b1, 16'd7, 16'd7, 1'b0, NO_REPORT);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      else
        send_beat(directed_rows[i].ovf, directed_rows[i].cap, directed_rows[i].pin,
                  directed_rows[i].period, directed_rows[i].high,
                  directed_rows[i].typed, directed_rows[i].report);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_register(REG_STABLE_LIMIT, HZ_W'(phase_limit[ph]));
      write_register(REG_CAPTURE_CLOCK_HZ, HZ_W'(phase_clock[ph]));
      write_register(REG_MIN_REF_FREQ, HZ_W'(phase_min[ph]));
      write_register(REG_MAX_REF_FREQ, HZ_W'(phase_max[ph]));
      run_random(PHASE_ITEMS);
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
